>>> sv/sle_pkg.sv
// Package with the transaction types, action and status codes of the sorted list engine.
`default_nettype none
package sle_pkg;

  localparam logic [2:0] ACT_INSERT    = 3'd0;
  localparam logic [2:0] ACT_DELETE    = 3'd1;
  localparam logic [2:0] ACT_LOOKUP    = 3'd2;
  localparam logic [2:0] ACT_DUMP_FWD  = 3'd3;
  localparam logic [2:0] ACT_DUMP_BWD  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] data_value;
  } sle_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] out_value;
    logic [4:0]         entry_count;
    logic               last_item;
  } sle_out_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } sle_cmp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DONE
  } sle_state_t;

endpackage
`default_nettype wire

>>> sv/sorted_list_engine.sv
// Top level of the sorted list engine: sequencer, entry RAM and shared comparator.
//
//  Channel | Signals                          | Direction | Payload
//  --------+----------------------------------+-----------+----------
//  in      | in_valid, in_ready, in_data      | input     | sle_in_t
//  out     | out_valid, out_ready, out_data   | output    | sle_out_t
//
// Each entry read passes through S_READ (address) and S_EXEC (compare); the result then goes
// through S_DONE into the output register. A scan that runs off its end (insert reaching slot 0,
// every delete, a lookup miss) goes from S_READ to S_DONE. Full, empty and undefined actions go
// straight to S_DONE. A dump emits one entry per S_READ, S_EXEC pass and waits while out is stalled.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// in_ready rises at the edge that registers the last result; a stalled result holds the sequencer.
`default_nettype none
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sle_in_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output sle_out_t  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  sle_state_t state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               match_r, match_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               res_found_r, res_found_nxt;
  logic               out_valid_r, out_valid_nxt;
  sle_out_t           out_data_r, out_data_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  sle_cmp_t           cmp;

  logic               out_free;
  logic               acc_done;
  logic [1:0]         acc_status;
  logic               scan_end;
  logic               dump_last;
  logic [CW-1:0]      idx_m1;
  logic [CW+4:0]      count_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_m1    = idx_r - ONE_C;
  assign count_ext = {5'd0, count_r};

  // Insert walks down from the hole at idx, so it reads the entry just below it.
  assign ram_raddr = (op_r == ACT_INSERT) ? idx_m1[AW-1:0] : idx_r[AW-1:0];

  sle_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sle_cmp u_cmp (
    .a   ($signed(ram_rdata)),
    .b   (val_r),
    .res (cmp)
  );

  // Decode of a new transaction: which ones finish without touching the RAM.
  always_comb begin
    acc_done   = 1'b0;
    acc_status = ST_OK;
    unique case (in_data.action)
      ACT_INSERT: begin
        acc_done   = (count_r == CAP_C);
        acc_status = ST_FULL;
      end
      ACT_DELETE, ACT_LOOKUP: begin
        acc_done = 1'b0;
      end
      ACT_DUMP_FWD, ACT_DUMP_BWD: begin
        acc_done   = (count_r == '0);
        acc_status = ST_EMPTY;
      end
      default: begin
        acc_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (op_r == ACT_INSERT) begin
      scan_end = (idx_r == '0);
    end else begin
      scan_end = (idx_r == count_r);
    end
    if (op_r == ACT_DUMP_FWD) begin
      dump_last = (idx_r == count_r - ONE_C);
    end else begin
      dump_last = (idx_r == '0);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = acc_done ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        if ((op_r == ACT_DUMP_FWD) || (op_r == ACT_DUMP_BWD)) begin
          state_nxt = S_EXEC;
        end else if (scan_end) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          ACT_INSERT: state_nxt = cmp.gt ? S_READ : S_DONE;
          ACT_LOOKUP: state_nxt = cmp.eq ? S_DONE : S_READ;
          ACT_DUMP_FWD, ACT_DUMP_BWD: begin
            if (out_free) begin
              state_nxt = dump_last ? S_IDLE : S_READ;
            end
          end
          default: state_nxt = S_READ;
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_nxt         = op_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    match_nxt      = match_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.action;
          val_nxt        = in_data.data_value;
          match_nxt      = 1'b0;
          res_status_nxt = acc_status;
          res_found_nxt  = 1'b0;
          if (in_data.action == ACT_INSERT) begin
            idx_nxt = count_r;
          end else if (in_data.action == ACT_DUMP_BWD) begin
            idx_nxt = count_r - ONE_C;
          end else begin
            idx_nxt = '0;
          end
        end
      end
      S_READ: begin
        if (scan_end) begin
          unique case (op_r)
            ACT_INSERT: begin
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = val_r;
              count_nxt      = count_r + ONE_C;
              res_status_nxt = ST_OK;
            end
            ACT_DELETE: begin
              if (match_r) begin
                count_nxt      = count_r - ONE_C;
                res_status_nxt = ST_OK;
                res_found_nxt  = 1'b1;
              end else begin
                res_status_nxt = ST_NOTFOUND;
              end
            end
            ACT_LOOKUP: begin
              res_status_nxt = ST_NOTFOUND;
            end
            default: begin
              res_status_nxt = res_status_r;
            end
          endcase
        end
      end
      S_EXEC: begin
        unique case (op_r)
          ACT_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_r[AW-1:0];
            if (cmp.gt) begin
              ram_wdata = ram_rdata;
              idx_nxt   = idx_m1;
            end else begin
              ram_wdata      = val_r;
              count_nxt      = count_r + ONE_C;
              res_status_nxt = ST_OK;
            end
          end
          ACT_DELETE: begin
            // Past the first match, every entry moves down one slot.
            if (match_r) begin
              ram_we    = 1'b1;
              ram_waddr = idx_m1[AW-1:0];
              ram_wdata = ram_rdata;
            end else if (cmp.eq) begin
              match_nxt = 1'b1;
            end
            idx_nxt = idx_r + ONE_C;
          end
          ACT_LOOKUP: begin
            if (cmp.eq) begin
              res_status_nxt = ST_OK;
              res_found_nxt  = 1'b1;
            end else begin
              idx_nxt = idx_r + ONE_C;
            end
          end
          ACT_DUMP_FWD, ACT_DUMP_BWD: begin
            if (out_free) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.status      = ST_OK;
              out_data_nxt.found       = 1'b0;
              out_data_nxt.out_value   = $signed(ram_rdata);
              out_data_nxt.entry_count = count_ext[4:0];
              out_data_nxt.last_item   = dump_last;
              idx_nxt = (op_r == ACT_DUMP_FWD) ? idx_r + ONE_C : idx_m1;
            end
          end
          default: begin
            idx_nxt = idx_r;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.found       = res_found_r;
          out_data_nxt.out_value   = '0;
          out_data_nxt.entry_count = count_ext[4:0];
          out_data_nxt.last_item   = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer idle right after accepting a transaction");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free && res_status_r == ST_FULL |-> count_r == CAP_C)
    else $error("full status issued with free slots");

  a_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_READ || state_r == S_EXEC))
    else $error("RAM written outside a scan");
`endif

endmodule
`default_nettype wire

>>> sv/sle_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> sv/sle_cmp.sv
// Shared signed comparator used by the insert, delete and lookup scans of the sequencer.
`default_nettype none
module sle_cmp
  import sle_pkg::*;
(
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output sle_cmp_t                res
);

  always_comb begin
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule
`default_nettype wire

>>> sim/sorted_list_engine_test.sv
// Self-checking testbench for the sorted list engine: directed table, random traffic, checker.
`timescale 1ns / 1ps
module sorted_list_engine_test;
  import sle_pkg::*;

  localparam int CAP = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * CAP + 8;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int PRESSURE_CYCLES = 300;
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [7:0]         reps;
    logic signed [15:0] step;
    logic               typed;
    sle_out_t           want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sle_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sle_out_t out_data;

  // Shadow copy of the list, updated when an input transaction is accepted.
  logic signed [31:0] shadow_list [CAP];
  int shadow_count;
  sle_out_t step_results [$];
  sle_out_t awaited_responses [$];
  stim_row_t directed_rows [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  int errors;
  int cycle_count;
  int items_accepted;
  int results_checked;
  int full_drops;
  int peak_count;
  sle_out_t mon_want;
  sle_out_t mon_got;

  sorted_list_engine #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sle_out_t make_response(input logic [1:0] status, input logic found,
                                             input logic signed [31:0] value, input int count,
                                             input logic last);
    sle_out_t r;
    r.status      = status;
    r.found       = found;
    r.out_value   = value;
    r.entry_count = count[4:0];
    r.last_item   = last;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] action, input logic signed [31:0] value,
                         input int reps, input int step, input logic typed,
                         input sle_out_t want);
    stim_row_t row;
    row.action = action;
    row.value  = value;
    row.reps   = reps[7:0];
    row.step   = step[15:0];
    row.typed  = typed;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  // Applies one action to the shadow list and leaves its responses in step_results.
  task automatic predict_list_response(input sle_in_t item);
    int pos;
    int i;
    logic signed [31:0] v;
    v = item.data_value;
    step_results.delete();
    case (item.action)
      ACT_INSERT: begin
        if (shadow_count >= CAP) begin
          full_drops++;
          step_results.push_back(make_response(ST_FULL, 1'b0, '0, shadow_count, 1'b1));
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_list[pos] < v) pos++;
          for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[pos] = v;
          shadow_count++;
          if (shadow_count > peak_count) peak_count = shadow_count;
          step_results.push_back(make_response(ST_OK, 1'b0, '0, shadow_count, 1'b1));
        end
      end
      ACT_DELETE, ACT_LOOKUP: begin
        pos = 0;
        while (pos < shadow_count && shadow_list[pos] != v) pos++;
        if (pos >= shadow_count) begin
          step_results.push_back(make_response(ST_NOTFOUND, 1'b0, '0, shadow_count, 1'b1));
        end else begin
          if (item.action == ACT_DELETE) begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
            shadow_count--;
          end
          step_results.push_back(make_response(ST_OK, 1'b1, '0, shadow_count, 1'b1));
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_BWD: begin
        if (shadow_count == 0) begin
          step_results.push_back(make_response(ST_EMPTY, 1'b0, '0, 0, 1'b1));
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            pos = (item.action == ACT_DUMP_FWD) ? i : shadow_count - 1 - i;
            step_results.push_back(make_response(ST_OK, 1'b0, shadow_list[pos], shadow_count,
                                                 i + 1 == shadow_count));
          end
        end
      end
      default: begin
        step_results.push_back(make_response(ST_OK, 1'b0, '0, shadow_count, 1'b1));
      end
    endcase
  endtask

  // Offers one input transaction and records what it should produce once accepted.
  task automatic send_item(input sle_in_t item, input logic typed, input sle_out_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_accepted++;
    predict_list_response(item);
    if (typed) begin
      awaited_responses.push_back(want);
    end else begin
      foreach (step_results[i]) awaited_responses.push_back(step_results[i]);
    end
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
  endtask

  // The receiver drops ready at random, or for a long stretch while hold_off counts down.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready = 1'b0;
      hold_off  = hold_off - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mon_got = out_data;
      if (awaited_responses.size() == 0) begin
        errors++;
        $display("%0t: unexpected response: expected none, got %h", $time, mon_got);
      end else begin
        mon_want = awaited_responses.pop_front();
        results_checked++;
        if (mon_got.status !== mon_want.status)
          flag_field("status", mon_want.status, mon_got.status);
        if (mon_got.found !== mon_want.found)
          flag_field("found", mon_want.found, mon_got.found);
        if (mon_got.out_value !== mon_want.out_value)
          flag_field("out_value", mon_want.out_value, mon_got.out_value);
        if (mon_got.entry_count !== mon_want.entry_count)
          flag_field("entry_count", mon_want.entry_count, mon_got.entry_count);
        if (mon_got.last_item !== mon_want.last_item)
          flag_field("last_item", mon_want.last_item, mon_got.last_item);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_list_engine_test: done, errors");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    sle_in_t item;
    sle_out_t none;
    int k;
    int step;
    int phase;
    int n;
    int roll;
    int insert_pct;
    logic signed [31:0] v;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    errors = 0;
    cycle_count = 0;
    items_accepted = 0;
    results_checked = 0;
    full_drops = 0;
    peak_count = 0;
    shadow_count = 0;
    none = '0;

    // Empty store first, then extremes, duplicates, a full store and deletes from it.
    add_row(ACT_DUMP_FWD, 0, 1, 0, 1'b1, make_response(ST_EMPTY, 1'b0, 0, 0, 1'b1));
    add_row(ACT_DUMP_BWD, -5, 1, 0, 1'b1, make_response(ST_EMPTY, 1'b0, 0, 0, 1'b1));
    add_row(ACT_LOOKUP, 7, 1, 0, 1'b1, make_response(ST_NOTFOUND, 1'b0, 0, 0, 1'b1));
    add_row(ACT_DELETE, 7, 1, 0, 1'b1, make_response(ST_NOTFOUND, 1'b0, 0, 0, 1'b1));
    add_row(ACT_SPARE_5, 3, 1, 0, 1'b1, make_response(ST_OK, 1'b0, 0, 0, 1'b1));
    add_row(ACT_INSERT, VAL_MAX, 1, 0, 1'b1, make_response(ST_OK, 1'b0, 0, 1, 1'b1));
    add_row(ACT_INSERT, VAL_MIN, 1, 0, 1'b1, make_response(ST_OK, 1'b0, 0, 2, 1'b1));
    add_row(ACT_INSERT, 0, 4, 0, 1'b0, none);
    add_row(ACT_INSERT, -1000, 10, 200, 1'b0, none);
    add_row(ACT_INSERT, 1, 1, 0, 1'b1, make_response(ST_FULL, 1'b0, 0, CAP, 1'b1));
    add_row(ACT_DUMP_FWD, 0, 1, 0, 1'b0, none);
    add_row(ACT_DUMP_BWD, 0, 1, 0, 1'b0, none);
    add_row(ACT_LOOKUP, VAL_MIN, 1, 0, 1'b1, make_response(ST_OK, 1'b1, 0, CAP, 1'b1));
    add_row(ACT_LOOKUP, 12345, 1, 0, 1'b1, make_response(ST_NOTFOUND, 1'b0, 0, CAP, 1'b1));
    add_row(ACT_DELETE, 0, 1, 0, 1'b1, make_response(ST_OK, 1'b1, 0, CAP - 1, 1'b1));
    add_row(ACT_DELETE, 12345, 1, 0, 1'b1,
            make_response(ST_NOTFOUND, 1'b0, 0, CAP - 1, 1'b1));
    add_row(ACT_DELETE, VAL_MAX, 1, 0, 1'b1, make_response(ST_OK, 1'b1, 0, CAP - 2, 1'b1));
    add_row(ACT_SPARE_7, -1, 1, 0, 1'b1, make_response(ST_OK, 1'b0, 0, CAP - 2, 1'b1));
    add_row(ACT_INSERT, -1, 1, 0, 1'b0, none);
    add_row(ACT_DUMP_FWD, 0, 1, 0, 1'b0, none);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      step = row.step;
      for (k = 0; k < row.reps; k++) begin
        item.action = row.action;
        item.data_value = row.value + k * step;
        send_item(item, row.typed, row.want);
      end
    end

    // Phases: no idling but one long receiver hold-off, sender idle, receiver stalling, both lightly.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 8 : 0;
      recv_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 8 : 0;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 20) hold_off = PRESSURE_CYCLES;
        // Alternate filling and draining stretches so the count rises and falls.
        insert_pct = ((n / 30) % 2 == 0) ? 55 : 15;
        roll = $urandom_range(99);
        if (roll < insert_pct) item.action = ACT_INSERT;
        else if (roll < 70) item.action = ACT_DELETE;
        else if (roll < 82) item.action = ACT_LOOKUP;
        else if (roll < 90) item.action = ACT_DUMP_FWD;
        else if (roll < 97) item.action = ACT_DUMP_BWD;
        else item.action = ACT_SPARE_5 + 3'($urandom_range(2));
        roll = $urandom_range(99);
        if (roll < 50 && shadow_count > 0) begin
          v = shadow_list[$urandom_range(shadow_count - 1)];
        end else if (roll < 75) begin
          v = $urandom_range(16);
          v = v - 8;
        end else if (roll < 80) begin
          v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
        end else begin
          v = $urandom;
        end
        item.data_value = v;
        send_item(item, 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Accepted %0d input transactions and checked %0d responses.",
             items_accepted, results_checked);
    $display("Peak list size %0d, %0d inserts dropped on a full list.", peak_count, full_drops);
    if (errors == 0) begin
      $display("sorted_list_engine_test: done, clean");
    end else begin
      $display("sorted_list_engine_test: done, errors");
    end
    $finish;
  end

endmodule
